// ----- hdl/ccod_pkg.sv -----
package ccod_pkg;
  localparam int QW = 32;
  localparam int CW = 31;
  localparam int NUM_REGS = 8;
  localparam int IDXW = 3;
  localparam int QUOW = 33;
  localparam int DIVW = 36;

  localparam logic signed [31:0] Q_ONE = 32'sd1048576;
  localparam logic signed [31:0] K2A = 32'sd52429;
  localparam logic signed [31:0] K3A = 32'sd104858;
  localparam logic signed [31:0] K4A = 32'sd0;
  localparam logic signed [31:0] KAS = 32'sd52429;
  localparam logic signed [31:0] J3 = 32'sd52429;
  localparam logic signed [31:0] J4 = 32'sd52429;
  localparam logic signed [31:0] LVL_0P2 = 32'sd209715;
  localparam logic signed [31:0] LVL_0P8 = 32'sd838861;
  localparam logic signed [31:0] MASS_FLOOR = 32'sd1677721;
  localparam logic signed [31:0] STOP_RATE = -32'sd524288;

  typedef enum logic [IDXW-1:0] {
    REG_APC_THR, REG_GROWTH, REG_CDK_SYN, REG_CDK_DEG,
    REG_APC_ACT, REG_APC_INACT, REG_DECAY_BASE, REG_DECAY_APC
  } reg_idx_e;

  typedef struct packed {
    logic [CW-1:0] apc_thr;
    logic [CW-1:0] growth;
    logic [CW-1:0] cdk_syn;
    logic [CW-1:0] cdk_deg;
    logic [CW-1:0] apc_act;
    logic [CW-1:0] apc_inact;
    logic [CW-1:0] decay_base;
    logic [CW-1:0] decay_apc;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] mx;
    logic signed [67:0] mn;
    mx = 68'sd2147483647;
    mn = -68'sd2147483648;
    if (v > mx) return 32'sh7fffffff;
    if (v < mn) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Product of two Q12.20 values, rounded half up, saturated.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd524288;
    return sat32(p >>> 20);
  endfunction
endpackage

// ----- hdl/ccod_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, round half away.
// The numerator magnitude times 2^21 is 53 bits wide; when its top 20 bits are
// not below the divisor the quotient is out of range, so only 33 bits are formed.
module ccod_div import ccod_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] n_i,
  input  logic signed [31:0] d_i,
  output logic signed [31:0] q_o
);
  localparam int STG = QUOW + 1;
  logic [QUOW-1:0] num_q [STG];
  logic [QUOW-1:0] quo_q [STG];
  logic [DIVW-1:0] rem_q [STG];
  logic [31:0]     den_q [STG];
  logic            neg_q [STG];
  logic            bad_q [STG];
  logic            ovf_q [STG];
  logic            zro_q [STG];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [31:0] mag;
      mag = n_i[31] ? 32'(-33'(n_i)) : 32'(n_i);
      num_q[0] <= {mag[11:0], 21'd0};
      quo_q[0] <= '0;
      rem_q[0] <= DIVW'(mag[31:12]);
      den_q[0] <= d_i;
      neg_q[0] <= n_i[31];
      bad_q[0] <= d_i[31] || (d_i == 32'sd0);
      ovf_q[0] <= {12'd0, mag[31:12]} >= d_i;
      zro_q[0] <= (n_i == 32'sd0);
      for (int s = 1; s < STG; s++) begin
        logic [DIVW-1:0] r;
        r = {rem_q[s-1][DIVW-2:0], num_q[s-1][QUOW-1]};
        num_q[s] <= num_q[s-1] << 1;
        if (r >= DIVW'(den_q[s-1])) begin
          rem_q[s] <= r - DIVW'(den_q[s-1]);
          quo_q[s] <= {quo_q[s-1][QUOW-2:0], 1'b1};
        end else begin
          rem_q[s] <= r;
          quo_q[s] <= {quo_q[s-1][QUOW-2:0], 1'b0};
        end
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        bad_q[s] <= bad_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        zro_q[s] <= zro_q[s-1];
      end
    end
  end

  always_comb begin
    logic [QUOW:0] m;
    logic signed [67:0] v;
    m = {1'b0, quo_q[STG-1]} + (QUOW+1)'(1);
    v = 68'(m[QUOW:1]);
    if (neg_q[STG-1]) v = -v;
    if (bad_q[STG-1] && zro_q[STG-1]) begin
      q_o = '0;
    end else if (bad_q[STG-1] || ovf_q[STG-1]) begin
      q_o = neg_q[STG-1] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      q_o = sat32(v);
    end
  end
endmodule

// ----- hdl/cell_cycle_ode_derivative.sv -----
// Cell-cycle ODE derivative pipeline.
// Input channel: in_valid_i/in_stall_o with five Q12.20 state values.
// Output channel: out_valid_o/out_stall_i with five rates (times 60),
// the stop flag and the root value.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i by the user
// only while idle; the block does not enforce it. Throughput is one item
// per cycle while the output is not stalled. An accepted item passes three
// stages of products, a divider of 34 stages (operand load and 33 quotient
// bits), the combine stage and the scaling stage that drives the outputs.
// A stall on the output freezes the whole pipeline; in_stall_o follows
// out_stall_i when the last stage holds an item.
// Reset clears all valid bits and loads the default register values.
module cell_cycle_ode_derivative import ccod_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDXW-1:0]    cfg_idx_i,
  input  logic [CW-1:0]      cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] cdk_level_i,
  input  logic signed [31:0] apc_level_i,
  input  logic signed [31:0] act_total_i,
  input  logic signed [31:0] act_active_i,
  input  logic signed [31:0] cell_mass_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] cdk_rate_o,
  output logic signed [31:0] apc_rate_o,
  output logic signed [31:0] act_total_rate_o,
  output logic signed [31:0] act_active_rate_o,
  output logic signed [31:0] mass_rate_o,
  output logic               stop_event_o,
  output logic signed [31:0] root_value_o
);
  localparam int DL = QUOW + 1;
  localparam int NV = DL + 5;
  cfg_t cfg_q;
  logic [NV-1:0] vld_q;
  logic en;

  assign en = !(vld_q[NV-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{apc_thr: 31'd209715, growth: 31'd5243, cdk_syn: 31'd52429,
                 cdk_deg: 31'd1048576, apc_act: 31'd3145728,
                 apc_inact: 31'd2097152, decay_base: 31'd5243,
                 decay_apc: 31'd1048576};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_APC_THR:    cfg_q.apc_thr <= cfg_data_i;
        REG_GROWTH:     cfg_q.growth <= cfg_data_i;
        REG_CDK_SYN:    cfg_q.cdk_syn <= cfg_data_i;
        REG_CDK_DEG:    cfg_q.cdk_deg <= cfg_data_i;
        REG_APC_ACT:    cfg_q.apc_act <= cfg_data_i;
        REG_APC_INACT:  cfg_q.apc_inact <= cfg_data_i;
        REG_DECAY_BASE: cfg_q.decay_base <= cfg_data_i;
        default:        cfg_q.decay_apc <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NV-2:0], in_valid_i};
  end

  logic signed [31:0] thr, gr, k1, k2b, k3b, k4b, kada, kadb;
  assign thr = 32'(cfg_q.apc_thr);
  assign gr = 32'(cfg_q.growth);
  assign k1 = 32'(cfg_q.cdk_syn);
  assign k2b = 32'(cfg_q.cdk_deg);
  assign k3b = 32'(cfg_q.apc_act);
  assign k4b = 32'(cfg_q.apc_inact);
  assign kada = 32'(cfg_q.decay_base);
  assign kadb = 32'(cfg_q.decay_apc);

  // Stage 1: inputs and first-level terms.
  logic signed [31:0] x1_q, x2_q, x3_q, x4_q, x5_q, om_q;
  logic signed [31:0] a_q, b_q, c_q, d_q, e_q, f_q, h_q, j_q, u_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= cdk_level_i; x2_q <= apc_level_i; x3_q <= act_total_i;
      x4_q <= act_active_i; x5_q <= cell_mass_i;
      om_q <= sat32(68'(Q_ONE) - 68'(apc_level_i));
      a_q <= qmul(k1, cell_mass_i);
      b_q <= qmul(k2b, apc_level_i);
      c_q <= qmul(k3b, act_active_i);
      d_q <= qmul(k4b, cdk_level_i);
      e_q <= qmul(kadb, apc_level_i);
      j_q <= sat32(68'(J3) + 68'(Q_ONE) - 68'(apc_level_i));
      h_q <= sat32(68'(J4) + 68'(apc_level_i));
      u_q <= qmul(gr, cell_mass_i);
      f_q <= sat32(68'(act_total_i) - 68'(act_active_i));
    end
  end

  // Stage 2.
  logic signed [31:0] y1_q, y2_q, y3_q, y4_q, y5_q, om2_q, a2_q, p2_q;
  logic signed [31:0] k3s_q, k4s_q, dg2_q, j2_q, h2_q, u2_q, f2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_q <= x1_q; y2_q <= x2_q; y3_q <= x3_q; y4_q <= x4_q; y5_q <= x5_q;
      om2_q <= om_q;
      a2_q <= a_q; j2_q <= j_q; h2_q <= h_q; u2_q <= u_q; f2_q <= f_q;
      p2_q <= sat32(68'(qmul(K2A, om_q)) + 68'(qmul(b_q, x1_q)));
      k3s_q <= sat32(68'(K3A) + 68'(c_q));
      k4s_q <= sat32(68'(K4A) + 68'(d_q));
      dg2_q <= sat32(68'(qmul(kada, om_q)) + 68'(e_q));
    end
  end

  // Stage 3: numerators and the CDK derivative.
  logic signed [31:0] z1_q, z2_q, z3_q, z4_q, z5_q, dx1_3_q, n1_3_q, n2_3_q;
  logic signed [31:0] j3r_q, h3r_q, u3_q, f3_q, dg3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      z1_q <= y1_q; z2_q <= y2_q; z3_q <= y3_q; z4_q <= y4_q; z5_q <= y5_q;
      j3r_q <= j2_q; h3r_q <= h2_q; u3_q <= u2_q; f3_q <= f2_q; dg3_q <= dg2_q;
      dx1_3_q <= sat32(68'(a2_q) - 68'(p2_q));
      n1_3_q <= qmul(k3s_q, om2_q);
      n2_3_q <= qmul(k4s_q, y2_q);
    end
  end

  // Stage 4: remaining products, alongside the divider operand load.
  logic signed [31:0] w1_q, w2_q, w5_q, dx1_4_q, dx3_4_q, dgx4_4_q, u4_q, f4_q, x4_4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q <= z1_q; w2_q <= z2_q; w5_q <= z5_q; dx1_4_q <= dx1_3_q;
      u4_q <= u3_q; f4_q <= f3_q;
      x4_4_q <= z4_q;
      dx3_4_q <= sat32(68'(KAS) - 68'(qmul(dg3_q, z3_q)));
      dgx4_4_q <= qmul(dg3_q, z4_q);
    end
  end

  logic signed [31:0] t1, t2;
  ccod_div u_div1 (.clk_i, .en_i(en), .n_i(n1_3_q), .d_i(j3r_q), .q_o(t1));
  ccod_div u_div2 (.clk_i, .en_i(en), .n_i(n2_3_q), .d_i(h3r_q), .q_o(t2));

  // Delay line to line up with the divider outputs.
  logic signed [31:0] dl_q [DL-1][9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= '{w1_q, w2_q, w5_q, dx1_4_q, dx3_4_q, dgx4_4_q, u4_q, f4_q, x4_4_q};
      for (int s = 1; s < DL - 1; s++) dl_q[s] <= dl_q[s-1];
    end
  end
  logic signed [31:0] v[9];
  assign v = dl_q[DL-2];

  // Combine stage.
  logic signed [31:0] dx1_c_q, dx2_c_q, dx3_c_q, dx4_c_q, x2_c_q, x5_c_q, u_c_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [31:0] dx2;
      logic signed [4:0] kai;
      logic signed [67:0] kx;
      dx2 = sat32(68'(t1) - 68'(t2));
      kai = '0;
      if (v[1] <= LVL_0P2 && dx2 < 0 && v[0] < LVL_0P8) kai = kai + 5'sd3;
      if (v[0] >= Q_ONE && v[3] > 0) kai = kai + 5'sd7;
      kx = 68'(sat32(68'(kai) * 68'(v[8])));
      dx1_c_q <= v[3]; dx2_c_q <= dx2; dx3_c_q <= v[4];
      dx4_c_q <= sat32(68'(qmul(Q_ONE, v[7])) - kx - 68'(v[5]));
      x2_c_q <= v[1]; x5_c_q <= v[2]; u_c_q <= v[6];
    end
  end

  // Scaling stage and output register.
  logic signed [31:0] r0_q, r1_q, r2_q, r3_q, r4_q, rt_q;
  logic st_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [31:0] r0;
      logic big, low;
      r0 = sat32(68'(dx1_c_q) * 68'sd60);
      big = x5_c_q > MASS_FLOOR;
      low = x2_c_q < thr;
      r0_q <= r0;
      r1_q <= sat32(68'(dx2_c_q) * 68'sd60);
      r2_q <= sat32(68'(dx3_c_q) * 68'sd60);
      r3_q <= sat32(68'(dx4_c_q) * 68'sd60);
      r4_q <= (big && low && r0 < 0) ? sat32(68'(x5_c_q) * -68'sd30)
                                      : sat32(68'(u_c_q) * 68'sd60);
      st_q <= big && low && r0 < STOP_RATE;
      rt_q <= (!big || r0 >= 0) ? Q_ONE : sat32(68'(x2_c_q) - 68'(thr));
    end
  end

  assign out_valid_o = vld_q[NV-1];
  assign cdk_rate_o = r0_q;
  assign apc_rate_o = r1_q;
  assign act_total_rate_o = r2_q;
  assign act_active_rate_o = r3_q;
  assign mass_rate_o = r4_q;
  assign stop_event_o = st_q;
  assign root_value_o = rt_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cdk_rate_o))
    else $error("stalled result changed");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_stop_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_event_o |-> cdk_rate_o < 0)
    else $error("stop flagged with non-negative rate");
endmodule

// ----- bench/testbench.sv -----
module testbench;
  import ccod_pkg::*;

  typedef struct {
    logic signed [31:0] x1, x2, x3, x4, x5;
  } state_t;

  typedef struct {
    logic signed [31:0] r0, r1, r2, r3, r4, root;
    logic               stop;
  } rates_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDXW-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] cdk_level_i = '0, apc_level_i = '0, act_total_i = '0;
  logic signed [31:0] act_active_i = '0, cell_mass_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] cdk_rate_o, apc_rate_o, act_total_rate_o, act_active_rate_o;
  logic signed [31:0] mass_rate_o, root_value_o;
  logic stop_event_o;

  cell_cycle_ode_derivative i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the registers.
  longint shadow_cfg [NUM_REGS];
  state_t pending_items[$];
  rates_t expected_rates[$];
  int errors = 0;
  int checked = 0;
  int stops = 0;
  longint cycle = 0;
  bit hold_off = 1'b0;
  bit drv_pause = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int long_hold = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clamp32((a * b + 524288) >>> 20);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint num;
    if (d <= 0) begin
      if (n > 0) return 64'sd2147483647;
      if (n < 0) return -64'sd2147483648;
      return 0;
    end
    num = n * 1048576;
    if (num >= 0) return clamp32((num + d / 2) / d);
    return clamp32(-((-num + d / 2) / d));
  endfunction

  function automatic rates_t derive_rates(state_t s);
    longint x1, x2, x3, x4, x5, om, dg, dx1, dx2, dx3, dx4, t1, t2, kai;
    longint r0, r4, thr;
    rates_t r;
    bit big, low;
    x1 = 64'(s.x1); x2 = 64'(s.x2); x3 = 64'(s.x3); x4 = 64'(s.x4); x5 = 64'(s.x5);
    thr = shadow_cfg[REG_APC_THR];
    om = clamp32(1048576 - x2);
    dg = clamp32(fx_mul(shadow_cfg[REG_DECAY_BASE], om)
                 + fx_mul(shadow_cfg[REG_DECAY_APC], x2));
    dx1 = clamp32(fx_mul(shadow_cfg[REG_CDK_SYN], x5)
                  - clamp32(fx_mul(52429, om)
                            + fx_mul(fx_mul(shadow_cfg[REG_CDK_DEG], x2), x1)));
    t1 = fx_div(fx_mul(clamp32(104858 + fx_mul(shadow_cfg[REG_APC_ACT], x4)), om),
                clamp32(52429 + 1048576 - x2));
    t2 = fx_div(fx_mul(clamp32(fx_mul(shadow_cfg[REG_APC_INACT], x1)), x2),
                clamp32(52429 + x2));
    dx2 = clamp32(t1 - t2);
    dx3 = clamp32(52429 - fx_mul(dg, x3));
    kai = 0;
    if (x2 <= 209715 && dx2 < 0 && x1 < 838861) kai += 3;
    if (x1 >= 1048576 && dx1 > 0) kai += 7;
    dx4 = clamp32(fx_mul(1048576, clamp32(x3 - x4)) - clamp32(kai * x4)
                  - fx_mul(dg, x4));
    r0 = clamp32(dx1 * 60);
    big = x5 > 1677721;
    low = x2 < thr;
    if (big && low && r0 < 0) r4 = clamp32(-30 * x5);
    else r4 = clamp32(fx_mul(shadow_cfg[REG_GROWTH], x5) * 60);
    r.r0 = 32'(r0);
    r.r1 = 32'(clamp32(dx2 * 60));
    r.r2 = 32'(clamp32(dx3 * 60));
    r.r3 = 32'(clamp32(dx4 * 60));
    r.r4 = 32'(r4);
    r.stop = big && low && r0 < -524288;
    r.root = 32'((x5 <= 1677721 || r0 >= 0) ? 64'sd1048576 : clamp32(x2 - thr));
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      3: return $signed($urandom_range(0, 4194304)) - 32'sd1048576;
      4: return $signed($urandom_range(1500000, 1900000));
      default: return $signed($urandom_range(0, 2621440));
    endcase
  endfunction

  function automatic state_t random_state();
    state_t s;
    s.x1 = pick_value(); s.x2 = pick_value(); s.x3 = pick_value();
    s.x4 = pick_value(); s.x5 = pick_value();
    // Steer part of the items into the stop-event region.
    if ($urandom_range(0, 3) == 0) begin
      s.x5 = $urandom_range(1677720, 2500000);
      s.x2 = $urandom_range(0, 300000);
    end
    return s;
  endfunction

  bit item_taken;
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    item_taken <= in_valid_i && !in_stall_o;
  end

  // Driver: bursts and gaps, pauses on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (item_taken || !in_valid_i) begin
        if (in_valid_i) void'(pending_items.pop_front());
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (burst_left == 0 && $urandom_range(0, 1) == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= $urandom_range(0, 6);
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 && !drv_pause) begin
          state_t s;
          s = pending_items[0];
          cdk_level_i <= s.x1; apc_level_i <= s.x2; act_total_i <= s.x3;
          act_active_i <= s.x4; cell_mass_i <= s.x5;
          in_valid_i <= 1'b1;
          expected_rates.insert(expected_rates.size(), derive_rates(s));
          if (burst_left > 0) burst_left <= burst_left - 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off counted here.
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall_i <= 1'b1;
    end else if (hold_off) begin
      long_hold <= 300;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (cycle % 64 < 20) ? ($urandom_range(0, 2) == 0) : 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rates_t e;
      if (expected_rates.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_rates.pop_front();
        checked++;
        if (stop_event_o) stops++;
        if (cdk_rate_o !== e.r0) begin
          $error("cdk_rate exp %0d got %0d", e.r0, cdk_rate_o); errors++;
        end
        if (apc_rate_o !== e.r1) begin
          $error("apc_rate exp %0d got %0d", e.r1, apc_rate_o); errors++;
        end
        if (act_total_rate_o !== e.r2) begin
          $error("act_total_rate exp %0d got %0d", e.r2, act_total_rate_o); errors++;
        end
        if (act_active_rate_o !== e.r3) begin
          $error("act_active_rate exp %0d got %0d", e.r3, act_active_rate_o); errors++;
        end
        if (mass_rate_o !== e.r4) begin
          $error("mass_rate exp %0d got %0d", e.r4, mass_rate_o); errors++;
        end
        if (stop_event_o !== e.stop) begin
          $error("stop_event exp %0d got %0d", e.stop, stop_event_o); errors++;
        end
        if (root_value_o !== e.root) begin
          $error("root_value exp %0d got %0d", e.root, root_value_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle > 400000) begin
      $display("timeout after %0d cycles", cycle);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_rates.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, longint value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CW-1:0];
    shadow_cfg[idx] = value & 64'h7fffffff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_item(state_t s);
    pending_items.insert(pending_items.size(), s);
  endtask

  task automatic queue_random(int n);
    repeat (n) add_item(random_state());
  endtask

  initial begin
    state_t s;
    logic signed [31:0] lv [4];
    shadow_cfg[REG_APC_THR] = 209715;
    shadow_cfg[REG_GROWTH] = 5243;
    shadow_cfg[REG_CDK_SYN] = 52429;
    shadow_cfg[REG_CDK_DEG] = 1048576;
    shadow_cfg[REG_APC_ACT] = 3145728;
    shadow_cfg[REG_APC_INACT] = 2097152;
    shadow_cfg[REG_DECAY_BASE] = 5243;
    shadow_cfg[REG_DECAY_APC] = 1048576;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, divisor edges, the inhibition cases, division.
    lv = '{32'sh7fffffff, 32'sh80000000, 0, -1};
    foreach (lv[i]) begin
      s = '{lv[i], lv[i], lv[i], lv[i], lv[i]};
      add_item(s);
    end
    add_item(state_t'{0, -52429, 1, 2, 3});            // zero divisor in t2
    add_item(state_t'{0, 1101005, 1, 2, 3});           // zero divisor in t1
    add_item(state_t'{0, 1200000, 0, 0, 3});           // negative divisor
    add_item(state_t'{500000, 100000, 900000, 800000, 1000000}); // kai 0
    add_item(state_t'{2097152, 500000, 900000, 800000, 30000000}); // kai 7
    add_item(state_t'{1048576, 0, 1000000, 900000, 30000000});
    add_item(state_t'{3000000, 100000, 1000000, 500000, 1677721});
    add_item(state_t'{3000000, 100000, 1000000, 500000, 1677722});
    add_item(state_t'{3000000, 209714, 1000000, 500000, 2000000});
    add_item(state_t'{3000000, 209715, 1000000, 500000, 2000000});
    wait_drained();

    queue_random(300);
    wait_drained();

    // Every register at the top of its range.
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_e'(i), 64'h7fffffff);
    queue_random(250);
    wait_drained();

    // All zero.
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_e'(i), 0);
    queue_random(250);
    wait_drained();

    // Random settings, with a long hold-off on the receiver in the first.
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(reg_idx_e'(i), ($urandom_range(0, 3) == 0) ? 64'($urandom)
                                                            : 64'($urandom_range(0, 4194304)));
      if (p == 0) begin
        @(negedge clk_i) hold_off <= 1'b1;
        @(negedge clk_i) hold_off <= 1'b0;
      end
      queue_random(250);
      wait_drained();
    end

    // Reset values again, and a sender pause until everything has come back.
    write_reg(REG_APC_THR, 209715);
    write_reg(REG_GROWTH, 5243);
    write_reg(REG_CDK_SYN, 52429);
    write_reg(REG_CDK_DEG, 1048576);
    write_reg(REG_APC_ACT, 3145728);
    write_reg(REG_APC_INACT, 2097152);
    write_reg(REG_DECAY_BASE, 5243);
    write_reg(REG_DECAY_APC, 1048576);
    queue_random(50);
    repeat (20) @(posedge clk_i);
    drv_pause = 1'b1;
    while (expected_rates.size() > 0) @(posedge clk_i);
    drv_pause = 1'b0;
    queue_random(100);
    wait_drained();

    $display("checked %0d results over six register settings, %0d stop events seen",
             checked, stops);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
